>>> design/inverse_transform_8x8_add_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the inverse transform block.
// ----------------------------------------------------------------------------
`ifndef INVERSE_TRANSFORM_8X8_ADD_TOP_MACROS_SVH
`define INVERSE_TRANSFORM_8X8_ADD_TOP_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is asserted.
`define ITX8_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check of a consequence in the cycle after its antecedent.
`define ITX8_ASSERT_NEXT(name, ante, cons, msg) \
  `ITX8_ASSERT(name, (ante) |=> (cons), msg)

`endif

>>> design/itx8_pkg.sv
// ----------------------------------------------------------------------------
// itx8_pkg
// Types, constants and the control program of the 8x8 inverse transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itx8_pkg;

  localparam int BlockSize = 64;
  localparam int LineLen   = 8;
  localparam int IdxW      = $clog2(BlockSize);
  localparam int LineW     = $clog2(LineLen);
  localparam int PassW     = LineW + 1;
  localparam int StoreW    = 24;
  localparam int CalcW     = 28;
  localparam int PcW       = 4;

  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(BlockSize - 1);
  localparam logic [LineW-1:0] LastElem = LineW'(LineLen - 1);
  localparam logic [PassW-1:0] LastPass = PassW'(2 * LineLen - 1);

  localparam logic [PcW-1:0] StLoad  = 4'd0;
  localparam logic [PcW-1:0] StRead  = 4'd1;
  localparam logic [PcW-1:0] StGap   = 4'd2;
  localparam logic [PcW-1:0] StBf1   = 4'd3;
  localparam logic [PcW-1:0] StBf2   = 4'd4;
  localparam logic [PcW-1:0] StBf3   = 4'd5;
  localparam logic [PcW-1:0] StWrite = 4'd6;
  localparam logic [PcW-1:0] StNext  = 4'd7;
  localparam logic [PcW-1:0] StEmit  = 4'd8;
  localparam logic [PcW-1:0] StWrap  = 4'd9;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_READ,
    OP_NOP,
    OP_BF1,
    OP_BF2,
    OP_BF3,
    OP_WRITE,
    OP_NEXT,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_ADVANCE,
    COND_LAST_REQ,
    COND_LINE_END,
    COND_LAST_PASS,
    COND_LAST_PIXEL,
    COND_JUMP
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic [7:0]         predicted_pixel;
  } req_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_of_block;
  } result_t;

  // Each step advances when its condition holds and otherwise goes to target.
  function automatic ucode_t ucode(input logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      StLoad:  w = '{op: OP_LOAD,  cond: COND_LAST_REQ,   target: StLoad};
      StRead:  w = '{op: OP_READ,  cond: COND_LINE_END,   target: StRead};
      StGap:   w = '{op: OP_NOP,   cond: COND_ADVANCE,    target: StGap};
      StBf1:   w = '{op: OP_BF1,   cond: COND_ADVANCE,    target: StBf1};
      StBf2:   w = '{op: OP_BF2,   cond: COND_ADVANCE,    target: StBf2};
      StBf3:   w = '{op: OP_BF3,   cond: COND_ADVANCE,    target: StBf3};
      StWrite: w = '{op: OP_WRITE, cond: COND_LINE_END,   target: StWrite};
      StNext:  w = '{op: OP_NEXT,  cond: COND_LAST_PASS,  target: StRead};
      StEmit:  w = '{op: OP_EMIT,  cond: COND_LAST_PIXEL, target: StEmit};
      StWrap:  w = '{op: OP_NOP,   cond: COND_JUMP,       target: StLoad};
      default: w = '{op: OP_NOP,   cond: COND_JUMP,       target: StLoad};
    endcase
    return w;
  endfunction

  // Rows come first, then columns.
  function automatic logic [IdxW-1:0] line_addr(input logic [PassW-1:0] pass,
                                                input logic [LineW-1:0] elem);
    logic [IdxW-1:0] a;
    if (pass[PassW-1]) begin
      a = {elem, pass[LineW-1:0]};
    end else begin
      a = {pass[LineW-1:0], elem};
    end
    return a;
  endfunction

endpackage

>>> design/inverse_transform_8x8_add_top.sv
// ----------------------------------------------------------------------------
// inverse_transform_8x8_add_top: 8x8 inverse integer transform with prediction add.
// One request per cycle while idle until 64 are in, then 16 line passes,
// bound by the single read and write port of the working store.
// Pixels then come out one per cycle. Reset clears the sequencer; the stores
// are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "inverse_transform_8x8_add_top_macros.svh"

module inverse_transform_8x8_add_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  itx8_pkg::req_t    req_i,
  output logic              result_strobe_o,
  output itx8_pkg::result_t result_o
);

  import itx8_pkg::*;

  logic [PcW-1:0]   pc_q, pc_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [PassW-1:0] pass_q, pass_d;
  ucode_t           uw;
  logic             accept;
  logic             cond_met;

  logic                    rd_pend_q;
  logic [LineW-1:0]        rd_idx_q;
  logic signed [StoreW-1:0] x_q [LineLen];

  logic signed [CalcW-1:0] xe [LineLen];
  logic signed [CalcW-1:0] e0_q, e1_q, e2_q, e3_q;
  logic signed [CalcW-1:0] o1_q, o3_q, o5_q, o7_q;
  logic signed [CalcW-1:0] f0_q, f1_q, f2_q, f3_q;
  logic signed [CalcW-1:0] g1_q, g3_q, g5_q, g7_q;

  logic                     ws_we;
  logic [IdxW-1:0]          ws_waddr;
  logic [StoreW-1:0]        ws_wdata;
  logic [IdxW-1:0]          ws_raddr;
  logic [StoreW-1:0]        ws_rdata;
  logic [7:0]               ps_rdata;

  logic                     em_pend_q;
  logic                     em_last_q;
  logic signed [StoreW:0]   wsum;
  logic signed [18:0]       rnd;
  logic signed [19:0]       recon;
  logic [7:0]               pix;
  logic                     strobe_q;
  result_t                  result_q;

  assign uw     = ucode(pc_q);
  assign busy   = (pc_q != StLoad);
  assign accept = start && !busy;

  always_comb begin
    case (uw.cond)
      COND_ADVANCE:    cond_met = 1'b1;
      COND_LAST_REQ:   cond_met = accept && (cnt_q == LastIdx);
      COND_LINE_END:   cond_met = (cnt_q[LineW-1:0] == LastElem);
      COND_LAST_PASS:  cond_met = (pass_q == LastPass);
      COND_LAST_PIXEL: cond_met = (cnt_q == LastIdx);
      COND_JUMP:       cond_met = 1'b0;
      default:         cond_met = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = cond_met ? pc_q + 4'd1 : uw.target;
  end

  always_comb begin
    cnt_d  = cnt_q;
    pass_d = pass_q;
    case (uw.op)
      OP_LOAD: begin
        if (accept) begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      OP_READ, OP_WRITE: begin
        cnt_d = {cnt_q[IdxW-1:LineW], cnt_q[LineW-1:0] + 3'd1};
      end
      OP_NEXT: begin
        pass_d = pass_q + 4'd1;
      end
      OP_EMIT: begin
        cnt_d = cnt_q + 6'd1;
      end
      default: begin
        cnt_d  = cnt_q;
        pass_d = pass_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= StLoad;
      cnt_q     <= '0;
      pass_q    <= '0;
      rd_pend_q <= 1'b0;
      em_pend_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      cnt_q     <= cnt_d;
      pass_q    <= pass_d;
      rd_pend_q <= (uw.op == OP_READ);
      em_pend_q <= (uw.op == OP_EMIT);
      strobe_q  <= em_pend_q;
    end
  end

  always_comb begin
    ws_we    = 1'b0;
    ws_waddr = cnt_q;
    ws_wdata = StoreW'(req_i.coefficient);
    if (uw.op == OP_LOAD) begin
      ws_we = accept;
    end else if (uw.op == OP_WRITE) begin
      ws_we    = 1'b1;
      ws_waddr = line_addr(pass_q, cnt_q[LineW-1:0]);
      ws_wdata = x_q[cnt_q[LineW-1:0]];
    end
    ws_raddr = (uw.op == OP_EMIT) ? cnt_q : line_addr(pass_q, cnt_q[LineW-1:0]);
  end

  itx8_ram #(
    .Width(StoreW),
    .Depth(BlockSize)
  ) u_work_ram (
    .clk_i  (clk_i),
    .we_i   (ws_we),
    .waddr_i(ws_waddr),
    .wdata_i(ws_wdata),
    .raddr_i(ws_raddr),
    .rdata_o(ws_rdata)
  );

  itx8_ram #(
    .Width(8),
    .Depth(BlockSize)
  ) u_pred_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(cnt_q),
    .wdata_i(req_i.predicted_pixel),
    .raddr_i(cnt_q),
    .rdata_o(ps_rdata)
  );

  always_comb begin
    for (int i = 0; i < LineLen; i++) begin
      xe[i] = CalcW'(x_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[LineW-1:0];
    if (rd_pend_q) begin
      x_q[rd_idx_q] <= $signed(ws_rdata);
    end
    if (uw.op == OP_BF1) begin
      e0_q <= xe[0] + xe[4];
      e1_q <= xe[0] - xe[4];
      e2_q <= (xe[2] >>> 1) - xe[6];
      e3_q <= xe[2] + (xe[6] >>> 1);
      o1_q <= xe[5] - xe[3] - xe[7] - (xe[7] >>> 1);
      o3_q <= xe[1] + xe[7] - xe[3] - (xe[3] >>> 1);
      o5_q <= xe[7] - xe[1] + xe[5] + (xe[5] >>> 1);
      o7_q <= xe[3] + xe[5] + xe[1] + (xe[1] >>> 1);
    end
    if (uw.op == OP_BF2) begin
      f0_q <= e0_q + e3_q;
      f1_q <= e1_q + e2_q;
      f2_q <= e1_q - e2_q;
      f3_q <= e0_q - e3_q;
      g1_q <= (o7_q >>> 2) + o1_q;
      g3_q <= o3_q + (o5_q >>> 2);
      g5_q <= (o3_q >>> 2) - o5_q;
      g7_q <= o7_q - (o1_q >>> 2);
    end
    if (uw.op == OP_BF3) begin
      x_q[0] <= StoreW'(f0_q + g7_q);
      x_q[7] <= StoreW'(f0_q - g7_q);
      x_q[1] <= StoreW'(f1_q + g5_q);
      x_q[6] <= StoreW'(f1_q - g5_q);
      x_q[2] <= StoreW'(f2_q + g3_q);
      x_q[5] <= StoreW'(f2_q - g3_q);
      x_q[3] <= StoreW'(f3_q + g1_q);
      x_q[4] <= StoreW'(f3_q - g1_q);
    end
  end

  always_comb begin
    wsum  = (StoreW + 1)'($signed(ws_rdata)) + 25'sd32;
    rnd   = wsum[StoreW:6];
    recon = 20'(rnd) + $signed({12'd0, ps_rdata});
    if (recon < 20'sd0) begin
      pix = 8'd0;
    end else if (recon > 20'sd255) begin
      pix = 8'd255;
    end else begin
      pix = recon[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    em_last_q <= (cnt_q == LastIdx);
    result_q  <= '{pixel: pix, last_of_block: em_last_q};
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

  `ITX8_ASSERT(a_last_pixel_idle, (result_strobe_o && result_o.last_of_block) |-> (pc_q == StLoad), "last pixel of a block while the sequencer is not idle")
  `ITX8_ASSERT(a_capture_in_read, rd_pend_q |-> (pc_q == StRead || pc_q == StGap), "store read data captured outside a line read")
  `ITX8_ASSERT(a_pass_cleared, (pc_q == StLoad || pc_q == StEmit) |-> (pass_q == '0), "pass counter not cleared outside the transform")
  `ITX8_ASSERT(a_line_complete, (pc_q == StBf1) |-> (cnt_q == '0), "butterfly started before a full line was read")
  `ITX8_ASSERT_NEXT(a_emit_strobe, em_pend_q, result_strobe_o, "emitted read did not produce a pixel strobe")

endmodule

>>> design/itx8_ram.sv
// ----------------------------------------------------------------------------
// itx8_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itx8_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/inverse_transform_8x8_add_top_tb.sv
// ----------------------------------------------------------------------------
// inverse_transform_8x8_add_top_tb
// Feeds 8x8 blocks of coefficients and predictions into the inverse transform
// and checks every reconstructed pixel against a block-level predictor that
// runs the row and column butterflies, rounds, adds the prediction and clips.
// A directed block covers the coefficient extremes; a random block of
// full-range, small or sparse coefficients follows once every pixel of the
// first block is back; each block not drawn quiet gets random request gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inverse_transform_8x8_add_top_tb;

  import itx8_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int TailCycles = 500;

  typedef enum int {
    BLK_ZERO_RESIDUAL,
    BLK_EXTREMES,
    BLK_FULL_RANGE,
    BLK_SMALL,
    BLK_SPARSE
  } block_kind_e;

  typedef struct {
    req_t req;
    bit   drain;
    bit   quiet;
  } pending_req_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  req_t    req_i = '0;
  logic    busy;
  logic    result_strobe_o;
  result_t result_o;

  pending_req_t pending_reqs[$];
  result_t      expected_pixels[$];

  int coef_block[BlockSize];
  int pred_block[BlockSize];
  int fill_count = 0;
  int n_sent = 0;
  int n_accepted = 0;
  int gap_left = 0;
  int error_count = 0;
  int cycle_count = 0;

  inverse_transform_8x8_add_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void butterfly_line(input int base, input int stride);
    int x[8];
    int y[8];
    int e0, e1, e2, e3, f0, f1, f2, f3;
    int o1, o3, o5, o7, g1, g3, g5, g7;
    for (int i = 0; i < 8; i++) begin
      x[i] = coef_block[(base + i * stride) % BlockSize];
    end
    e0 = x[0] + x[4];
    e1 = x[0] - x[4];
    e2 = (x[2] >>> 1) - x[6];
    e3 = x[2] + (x[6] >>> 1);
    f0 = e0 + e3;
    f1 = e1 + e2;
    f2 = e1 - e2;
    f3 = e0 - e3;
    o1 = -x[3] + x[5] - x[7] - (x[7] >>> 1);
    o3 = x[1] + x[7] - x[3] - (x[3] >>> 1);
    o5 = -x[1] + x[7] + x[5] + (x[5] >>> 1);
    o7 = x[3] + x[5] + x[1] + (x[1] >>> 1);
    g1 = (o7 >>> 2) + o1;
    g3 = o3 + (o5 >>> 2);
    g5 = (o3 >>> 2) - o5;
    g7 = o7 - (o1 >>> 2);
    y[0] = f0 + g7;
    y[7] = f0 - g7;
    y[1] = f1 + g5;
    y[6] = f1 - g5;
    y[2] = f2 + g3;
    y[5] = f2 - g3;
    y[3] = f3 + g1;
    y[4] = f3 - g1;
    for (int i = 0; i < 8; i++) begin
      coef_block[(base + i * stride) % BlockSize] = y[i];
    end
  endfunction

  function automatic void reconstruct_block();
    result_t px;
    int v;
    for (int k = 0; k < LineLen; k++) begin
      butterfly_line(k * LineLen, 1);
    end
    for (int k = 0; k < LineLen; k++) begin
      butterfly_line(k, LineLen);
    end
    for (int k = 0; k < BlockSize; k++) begin
      v = pred_block[k] + ((coef_block[k] + 32) >>> 6);
      if (v < 0) begin
        v = 0;
      end
      if (v > 255) begin
        v = 255;
      end
      px.pixel = v[7:0];
      px.last_of_block = (k == BlockSize - 1);
      expected_pixels.push_back(px);
    end
  endfunction

  function automatic void take_request(input req_t r);
    coef_block[fill_count] = int'($signed(r.coefficient));
    pred_block[fill_count] = int'(r.predicted_pixel);
    fill_count++;
    if (fill_count == BlockSize) begin
      reconstruct_block();
      fill_count = 0;
    end
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_request(input int coef, input int pred, input bit drain,
                                      input bit quiet);
    pending_req_t p;
    p.req.coefficient = coef[15:0];
    p.req.predicted_pixel = pred[7:0];
    p.drain = drain;
    p.quiet = quiet;
    pending_reqs.push_back(p);
  endfunction

  function automatic void add_block(input block_kind_e kind, input bit drain);
    int extremes[5] = '{32767, -32768, 0, 1, -1};
    int coef;
    int pred;
    bit quiet;
    quiet = ($urandom_range(0, 2) == 0);
    for (int k = 0; k < BlockSize; k++) begin
      pred = $urandom_range(0, 255);
      case (kind)
        BLK_ZERO_RESIDUAL: begin
          coef = 0;
          pred = (k * 255) / (BlockSize - 1);
        end
        BLK_EXTREMES: begin
          coef = extremes[k % 5];
          pred = (k % 2 == 0) ? 0 : 255;
        end
        BLK_FULL_RANGE: coef = $urandom_range(0, 65535);
        BLK_SMALL: coef = int'($urandom_range(0, 1023)) - 512;
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            coef = $urandom_range(0, 65535);
          end else if ($urandom_range(0, 3) == 0) begin
            coef = int'($urandom_range(0, 63)) - 32;
          end else begin
            coef = 0;
          end
        end
      endcase
      add_request(coef, pred, drain && k == 0, quiet);
    end
  endfunction

  always @(negedge clk_i) begin
    pending_req_t item;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (n_accepted == n_sent) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain && expected_pixels.size() != 0)) begin
        item = pending_reqs.pop_front();
        req_i <= item.req;
        start <= 1'b1;
        n_sent++;
        gap_left = pick_gap(item.quiet);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (result_strobe_o === 1'b1) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %0d arrived with none expected", result_o.pixel));
        end else begin
          want = expected_pixels.pop_front();
          if (result_o.pixel !== want.pixel) begin
            report_mismatch($sformatf("pixel got %0d want %0d", result_o.pixel, want.pixel));
          end
          if (result_o.last_of_block !== want.last_of_block) begin
            report_mismatch($sformatf("last_of_block got %b want %b",
                                      result_o.last_of_block, want.last_of_block));
          end
        end
      end
      if (start && busy === 1'b0) begin
        take_request(req_i);
        n_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    add_block(BLK_EXTREMES, 1'b0);
    add_block(block_kind_e'($urandom_range(BLK_FULL_RANGE, BLK_SPARSE)), 1'b1);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_reqs.size() != 0 || n_accepted != n_sent) begin
      @(posedge clk_i);
    end
    while (expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
